[rtl/core/pspm_pkg.sv]
// Package with the constants and transfer types of the probe packet sequence monitor.
`default_nettype none
package pspm_pkg;

	localparam int unsigned MAX_PACKET_BYTES = 2048;
	localparam int unsigned HDR_BYTES        = 28;

	localparam logic [11:0] HDR_LEN       = 12'(HDR_BYTES);
	localparam logic [15:0] PAYLOAD_LIMIT = 16'(MAX_PACKET_BYTES - HDR_BYTES);
	localparam logic [31:0] MAGIC_WORD    = 32'h4F4E3344;
	localparam logic [15:0] PROTO_VERSION = 16'd1;

	localparam logic [1:0] KIND_PACKET = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_STOP   = 2'd2;

	localparam logic [15:0] TYPE_HELLO = 16'd0;
	localparam logic [15:0] TYPE_ECHO  = 16'd2;
	localparam logic [15:0] TYPE_END   = 16'd4;

	localparam logic [1:0] REPLY_NONE   = 2'd0;
	localparam logic [1:0] REPLY_ECHO   = 2'd1;
	localparam logic [1:0] REPLY_REPORT = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] magic;
		logic [15:0] version;
		logic [15:0] packet_type;
		logic [31:0] run_id;
		logic [31:0] sequence_req;
		logic [63:0] send_stamp;
		logic [15:0] payload_bytes;
		logic [11:0] packet_length;
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
	} item_t;

	typedef struct packed {
		logic [1:0]  reply_type;
		logic [31:0] reply_run_id;
		logic [31:0] reply_sequence;
		logic [63:0] reply_ticks;
		logic [31:0] rx_packets;
		logic [31:0] rx_bytes;
		logic [31:0] lost_count;
		logic [31:0] duplicate_count;
		logic [31:0] reorder_count;
		logic        is_running;
		logic        accepted;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/probe_packet_sequence_monitor.sv]
// Top level of the probe packet sequence monitor.
// The monitor takes one item per clock cycle while the result side does not stall, and
// returns one result for each item: the item is captured in an input register, and the
// header check, run filter and counter update are done combinationally against the state
// registers, whose new values are loaded together with the result register. The state
// registers update on every transfer, which sets the rate of one item per cycle; a stall on
// the result side holds both stages and is passed back to the input within the same cycle.
// Counters wrap as unsigned 32-bit values; state registers and valid flags clear on reset.
`default_nettype none
module probe_packet_sequence_monitor
	import pspm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] magic,
	input  wire logic [15:0] version,
	input  wire logic [15:0] packet_type,
	input  wire logic [31:0] run_id,
	input  wire logic [31:0] sequence_req,
	input  wire logic [63:0] send_stamp,
	input  wire logic [15:0] payload_bytes,
	input  wire logic [11:0] packet_length,
	input  wire logic [31:0] peer_addr,
	input  wire logic [15:0] peer_port,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       reply_type,
	output logic [31:0]      reply_run_id,
	output logic [31:0]      reply_sequence,
	output logic [63:0]      reply_ticks,
	output logic [31:0]      rx_packets,
	output logic [31:0]      rx_bytes,
	output logic [31:0]      lost_count,
	output logic [31:0]      duplicate_count,
	output logic [31:0]      reorder_count,
	output logic             is_running,
	output logic             accepted
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res_s2;

	always_comb begin
		in_item.kind          = kind;
		in_item.magic         = magic;
		in_item.version       = version;
		in_item.packet_type   = packet_type;
		in_item.run_id        = run_id;
		in_item.sequence_req  = sequence_req;
		in_item.send_stamp    = send_stamp;
		in_item.payload_bytes = payload_bytes;
		in_item.packet_length = packet_length;
		in_item.peer_addr     = peer_addr;
		in_item.peer_port     = peer_port;
	end

	pspm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pspm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.valid_s2  (out_valid),
		.res_s2    (res_s2),
		.out_stall (out_stall)
	);

	assign reply_type      = res_s2.reply_type;
	assign reply_run_id    = res_s2.reply_run_id;
	assign reply_sequence  = res_s2.reply_sequence;
	assign reply_ticks     = res_s2.reply_ticks;
	assign rx_packets      = res_s2.rx_packets;
	assign rx_bytes        = res_s2.rx_bytes;
	assign lost_count      = res_s2.lost_count;
	assign duplicate_count = res_s2.duplicate_count;
	assign reorder_count   = res_s2.reorder_count;
	assign is_running      = res_s2.is_running;
	assign accepted        = res_s2.accepted;

endmodule
`default_nettype wire

[rtl/core/pspm_in_reg.sv]
// Input register stage that captures one item per transfer.
`default_nettype none
module pspm_in_reg
	import pspm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire item_t in_item,
	input  wire logic  advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic load;

	assign load     = !valid_s1 || advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

[rtl/core/pspm_engine.sv]
// Validation, run filter, sequence counters and the result register.
`default_nettype none
module pspm_engine
	import pspm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  valid_s1,
	input  wire item_t item_s1,
	output logic       advance,
	output logic       valid_s2,
	output result_t    res_s2,
	input  wire logic  out_stall
);

	typedef struct packed {
		logic        running;
		logic        pinned;
		logic [31:0] pinned_run;
		logic [31:0] pinned_addr;
		logic [15:0] pinned_port;
		logic [31:0] packet_counter;
		logic [31:0] byte_counter;
		logic [31:0] lost_counter;
		logic [31:0] duplicate_counter;
		logic [31:0] reorder_counter;
		logic [31:0] highest_sequence;
		logic        sequence_seen;
	} state_t;

	state_t  st_q;
	state_t  nxt;
	result_t res;
	logic    hdr_ok;
	logic    peer_match;
	logic    seq_gap;
	logic    seq_above;
	logic [1:0] reply;
	logic    acc;

	assign advance = !valid_s2 || !out_stall;

	always_comb begin
		hdr_ok = (item_s1.packet_length >= HDR_LEN)
			&& (item_s1.magic == MAGIC_WORD)
			&& (item_s1.version == PROTO_VERSION)
			&& (item_s1.payload_bytes == {4'd0, item_s1.packet_length - HDR_LEN})
			&& (item_s1.payload_bytes <= PAYLOAD_LIMIT);
		peer_match = st_q.pinned
			&& (item_s1.run_id == st_q.pinned_run)
			&& (item_s1.peer_addr == st_q.pinned_addr)
			&& (item_s1.peer_port == st_q.pinned_port);
		seq_gap = {1'b0, item_s1.sequence_req} > ({1'b0, st_q.highest_sequence} + 33'd1);
		seq_above = item_s1.sequence_req > st_q.highest_sequence;
		nxt   = st_q;
		reply = REPLY_NONE;
		acc   = 1'b0;
		case (item_s1.kind)
			KIND_START: begin
				nxt.running       = 1'b1;
				nxt.pinned        = 1'b0;
				nxt.sequence_seen = 1'b0;
			end
			KIND_STOP: begin
				nxt.running = 1'b0;
				nxt.pinned  = 1'b0;
			end
			KIND_PACKET: begin
				if (st_q.running && hdr_ok) begin
					if (item_s1.packet_type == TYPE_HELLO) begin
						nxt.packet_counter    = '0;
						nxt.byte_counter      = '0;
						nxt.lost_counter      = '0;
						nxt.duplicate_counter = '0;
						nxt.reorder_counter   = '0;
						nxt.highest_sequence  = '0;
						nxt.sequence_seen     = 1'b0;
						nxt.running           = 1'b1;
						nxt.pinned            = 1'b1;
						nxt.pinned_run        = item_s1.run_id;
						nxt.pinned_addr       = item_s1.peer_addr;
						nxt.pinned_port       = item_s1.peer_port;
						reply = REPLY_ECHO;
						acc   = 1'b1;
					end else if (peer_match) begin
						acc = 1'b1;
						if (item_s1.packet_type == TYPE_END) begin
							reply       = REPLY_REPORT;
							nxt.running = 1'b0;
						end else begin
							nxt.packet_counter = st_q.packet_counter + 32'd1;
							nxt.byte_counter   = st_q.byte_counter
								+ {20'd0, item_s1.packet_length};
							if (st_q.sequence_seen) begin
								if (seq_gap) begin
									nxt.lost_counter = st_q.lost_counter
										+ (item_s1.sequence_req - st_q.highest_sequence)
										- 32'd1;
								end else if (item_s1.sequence_req == st_q.highest_sequence) begin
									nxt.duplicate_counter = st_q.duplicate_counter + 32'd1;
								end else if (!seq_above) begin
									nxt.reorder_counter = st_q.reorder_counter + 32'd1;
								end
							end
							if (!st_q.sequence_seen || seq_above) begin
								nxt.highest_sequence = item_s1.sequence_req;
								nxt.sequence_seen    = 1'b1;
							end
							if (item_s1.packet_type == TYPE_ECHO) begin
								reply = REPLY_ECHO;
							end
						end
					end
				end
			end
			default: begin
				nxt = st_q;
			end
		endcase
		res.reply_type      = reply;
		res.reply_run_id    = (reply != REPLY_NONE) ? item_s1.run_id : '0;
		res.reply_sequence  = (reply != REPLY_NONE) ? item_s1.sequence_req : '0;
		res.reply_ticks     = (reply != REPLY_NONE) ? item_s1.send_stamp : '0;
		res.rx_packets      = nxt.packet_counter;
		res.rx_bytes        = nxt.byte_counter;
		res.lost_count      = nxt.lost_counter;
		res.duplicate_count = nxt.duplicate_counter;
		res.reorder_count   = nxt.reorder_counter;
		res.is_running      = nxt.running;
		res.accepted        = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				st_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

[rtl/core/pspm_checker.sv]
// Port-level checks on the result channel of the monitor, with its bind statement.
`default_nettype none
module pspm_checker
	import pspm_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  reply_type,
	input wire logic [31:0] reply_run_id,
	input wire logic [31:0] reply_sequence,
	input wire logic [63:0] reply_ticks,
	input wire logic [31:0] rx_packets,
	input wire logic        is_running,
	input wire logic        accepted
);

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rx_packets) && $stable(reply_type))
		else $error("stalled result was dropped or changed");

	// Only an accepted packet can cause a reply.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> reply_type == REPLY_NONE)
		else $error("reply without an accepted packet");

	// Without a reply the copied fields are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_type == REPLY_NONE |->
			reply_run_id == '0 && reply_sequence == '0 && reply_ticks == '0)
		else $error("reply fields set without a reply");

	// A report ends the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_type == REPLY_REPORT |-> !is_running)
		else $error("still running after a report");

	// A transfer that takes a reply leaves the block running only for echo replies.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_type == REPLY_ECHO |-> is_running && accepted)
		else $error("echo reply while not running");

endmodule

bind probe_packet_sequence_monitor pspm_checker u_pspm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.reply_type     (reply_type),
	.reply_run_id   (reply_run_id),
	.reply_sequence (reply_sequence),
	.reply_ticks    (reply_ticks),
	.rx_packets     (rx_packets),
	.is_running     (is_running),
	.accepted       (accepted)
);
`default_nettype wire
